### rtl/rhc_pkg.sv
`default_nettype none
package rhc_pkg;

  localparam int unsigned CompW = 8;
  localparam int unsigned NumW  = 24;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned MaskW = 13;

  // value = 10000*max/255 as a multiply by ceil(2^30/255) and a shift by 30
  localparam int unsigned RecipW   = 23;
  localparam int unsigned ValShift = 30;
  localparam logic [RecipW-1:0] ValRecip = 23'd4210753;

  // dividend/divisor pairs handed from the front to the divider pipeline
  typedef struct packed {
    logic [NumW-1:0]  hue_num;
    logic [CompW-1:0] hue_den;
    logic [NumW-1:0]  sat_num;
    logic [CompW-1:0] sat_den;
    logic [NumW-1:0]  val_num;
  } div_job_t;

endpackage
`default_nettype wire

### rtl/rgb_to_hsv_color_classifier_unit.sv
`default_nettype none
// channel   direction  ports
// command   in         start, busy, red_i, green_i, blue_i
// result    out        valid_o, hue_o, saturation_o, brightness_o, color_mask_o
//
// One pixel per clock. An accepted pixel passes the front register, a queue
// slot, the divider entry, the 16-stage bit-per-stage divider pipeline and
// the output register, and then the result strobe rises. Reset empties the
// front register, the two-entry queue and all
// stage valids. The result side cannot stall; the back end drains the queue
// every cycle, so busy stays low in normal operation.
module rgb_to_hsv_color_classifier_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             valid_o,
  output logic [15:0]      hue_o,
  output logic [13:0]      saturation_o,
  output logic [13:0]      brightness_o,
  output logic [12:0]      color_mask_o
);
  import rhc_pkg::*;

  logic     push, full, pop;
  div_job_t fjob, qjob;

  rhc_front u_front (
    .clk_i, .rst_ni, .start, .busy, .red_i, .green_i, .blue_i,
    .push_o(push), .job_o(fjob), .full_i(full)
  );

  rhc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob),
    .full_o(full), .pop_o(pop), .job_o(qjob)
  );

  rhc_back u_back (
    .clk_i, .rst_ni, .pop_i(pop), .job_i(qjob),
    .valid_o, .hue_o, .saturation_o, .brightness_o, .color_mask_o
  );

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> hue_o < 16'd36000) else $error("hue out of range");
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> saturation_o <= 14'd10000) else $error("saturation out of range");
  a_black_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o > 14'd1000) |-> !color_mask_o[0])
    else $error("black set on lit pixel");

endmodule
`default_nettype wire

### rtl/rhc_front.sv
`default_nettype none
module rhc_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [7:0]             red_i,
  input  wire logic [7:0]             green_i,
  input  wire logic [7:0]             blue_i,
  output logic                        push_o,
  output rhc_pkg::div_job_t           job_o,
  input  wire logic                   full_i
);
  import rhc_pkg::*;

  logic             valid_q, valid_d;
  div_job_t         job_q, job_d;
  logic [CompW-1:0] mx, mn, d;
  logic             accept;

  assign busy   = valid_q && full_i;
  assign accept = start && !busy;
  assign push_o = valid_q && !full_i;
  assign job_o  = job_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;

    job_d = '0;
    job_d.hue_den = 8'd1;
    if (d != '0) begin
      job_d.hue_den = d;
      if (red_i >= green_i && red_i >= blue_i) begin
        if (green_i >= blue_i) begin
          job_d.hue_num = NumW'(24'd6000 * NumW'(green_i - blue_i));
        end else begin
          job_d.hue_num = NumW'(24'd36000 * NumW'(d) - 24'd6000 * NumW'(blue_i - green_i));
        end
      end else if (green_i >= blue_i) begin
        // blue may sit below red here; the sum stays non-negative
        job_d.hue_num = NumW'(24'd12000 * NumW'(d) + 24'd6000 * NumW'(blue_i)
                              - 24'd6000 * NumW'(red_i));
      end else begin
        job_d.hue_num = NumW'(24'd24000 * NumW'(d) + 24'd6000 * NumW'(red_i)
                              - 24'd6000 * NumW'(green_i));
      end
    end
    job_d.sat_den = (mx == '0) ? 8'd1 : mx;
    job_d.sat_num = NumW'(24'd10000 * NumW'(d));
    job_d.val_num = NumW'(24'd10000 * NumW'(mx));
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (push_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) job_q <= job_d;
  end

endmodule
`default_nettype wire

### rtl/rhc_queue.sv
`default_nettype none
module rhc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  rhc_pkg::div_job_t  job_i,
  output logic               full_o,
  output logic               pop_o,
  output rhc_pkg::div_job_t  job_o
);
  import rhc_pkg::*;

  div_job_t   mem_q [0:1];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  // the back end never stalls: drain every cycle
  assign pop_o  = (cnt_q != 2'd0);
  assign job_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_o) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop_o) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule
`default_nettype wire

### rtl/rhc_back.sv
`default_nettype none
module rhc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_i,
  input  rhc_pkg::div_job_t  job_i,
  output logic               valid_o,
  output logic [15:0]        hue_o,
  output logic [13:0]        saturation_o,
  output logic [13:0]        brightness_o,
  output logic [12:0]        color_mask_o
);
  import rhc_pkg::*;

  logic             vld_q [0:QuoW];
  logic [NumW-1:0]  hr_q  [0:QuoW];
  logic [NumW-1:0]  sr_q  [0:QuoW];
  logic [CompW-1:0] hd_q  [0:QuoW];
  logic [CompW-1:0] sd_q  [0:QuoW];
  logic [QuoW-1:0]  hq_q  [0:QuoW];
  logic [QuoW-1:0]  sq_q  [0:QuoW];
  logic [QuoW-1:0]  vq_q  [0:QuoW];

  logic [NumW+RecipW-1:0] vprod;
  logic [15:0]      h;
  logic [13:0]      s, v;
  logic [MaskW-1:0] mask;
  logic             lit, chroma;

  // divide by the full scale through the reciprocal
  assign vprod = (NumW+RecipW)'(job_i.val_num) * (NumW+RecipW)'(ValRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hr_q[0] <= job_i.hue_num;
    sr_q[0] <= job_i.sat_num;
    hd_q[0] <= job_i.hue_den;
    sd_q[0] <= job_i.sat_den;
    hq_q[0] <= '0;
    sq_q[0] <= '0;
    vq_q[0] <= vprod[ValShift +: QuoW];
  end

  // one restoring quotient bit per stage, most significant first
  for (genvar g = 0; g < QuoW; g++) begin : g_stage
    localparam int unsigned Sh = QuoW - 1 - g;
    logic [NumW-1:0] hden, sden;
    logic            hb, sb;

    always_comb begin
      hden = NumW'(hd_q[g]) << Sh;
      sden = NumW'(sd_q[g]) << Sh;
      hb   = hr_q[g] >= hden;
      sb   = sr_q[g] >= sden;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      hr_q[g+1] <= hb ? hr_q[g] - hden : hr_q[g];
      sr_q[g+1] <= sb ? sr_q[g] - sden : sr_q[g];
      hd_q[g+1] <= hd_q[g];
      sd_q[g+1] <= sd_q[g];
      hq_q[g+1] <= {hq_q[g][QuoW-2:0], hb};
      sq_q[g+1] <= {sq_q[g][QuoW-2:0], sb};
      vq_q[g+1] <= vq_q[g];
    end
  end

  always_comb begin
    h      = hq_q[QuoW];
    s      = sq_q[QuoW][13:0];
    v      = vq_q[QuoW][13:0];
    lit    = v >= 14'd1000;
    chroma = s >= 14'd1500;
    mask   = '0;
    mask[0]  = v <= 14'd1000;
    mask[1]  = s <= 14'd1500 && v >= 14'd6500;
    mask[2]  = s <= 14'd1500 && lit && v <= 14'd6500;
    mask[3]  = (h <= 16'd1100 || h >= 16'd35100) && s >= 14'd7000 && lit;
    mask[4]  = h >= 16'd31000 && h <= 16'd35100 && chroma && lit;
    mask[5]  = h >= 16'd1100 && h <= 16'd4500 && chroma && v >= 14'd7500;
    mask[6]  = h >= 16'd1100 && h <= 16'd4500 && chroma && lit && v <= 14'd7500;
    mask[7]  = h >= 16'd4500 && h <= 16'd6400 && chroma && lit;
    mask[8]  = h >= 16'd6400 && h <= 16'd15000 && chroma && lit;
    mask[9]  = h >= 16'd15000 && h <= 16'd18000 && chroma && lit;
    mask[10] = h >= 16'd18000 && h <= 16'd25500 && chroma && lit;
    mask[11] = h >= 16'd25500 && h <= 16'd31000 && s >= 14'd5000 && lit;
    mask[12] = h >= 16'd25500 && h <= 16'd31000 && chroma && s <= 14'd5000 && lit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o        <= h;
    saturation_o <= s;
    brightness_o <= v;
    color_mask_o <= mask;
  end

endmodule
`default_nettype wire

### tb/sv/rgb_to_hsv_color_classifier_checker.sv
module rgb_to_hsv_color_classifier_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        valid_i,
  input  logic [15:0] hue_i,
  input  logic [13:0] saturation_i,
  input  logic [13:0] brightness_i,
  input  logic [12:0] color_mask_i,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] hue;
    logic [13:0] sat;
    logic [13:0] val;
    logic [12:0] mask;
  } hsv_pixel_t;

  hsv_pixel_t expected_pixels[$];
  int mismatches = 0;

  function automatic bit in_bin(int unsigned x, int unsigned lo, int unsigned hi);
    return x >= lo && x <= hi;
  endfunction

  function automatic hsv_pixel_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    int unsigned r, g, b, mx, mn, d, h, s, v;
    logic [12:0] m;
    hsv_pixel_t p;
    r = 32'(r8); g = 32'(g8); b = 32'(b8);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) h = 0;
    else if (r >= g && r >= b) begin
      if (g >= b) h = (6000 * (g - b)) / d;
      else h = (36000 * d - 6000 * (b - g)) / d;
    end else if (g >= b) h = (12000 * d + 6000 * b - 6000 * r) / d;
    else h = (24000 * d + 6000 * r - 6000 * g) / d;
    s = (mx == 0) ? 0 : (10000 * d) / mx;
    v = (10000 * mx) / 255;
    m = '0;
    m[0]  = v <= 1000;
    m[1]  = s <= 1500 && v >= 6500;
    m[2]  = s <= 1500 && in_bin(v, 1000, 6500);
    m[3]  = (h <= 1100 || h >= 35100) && s >= 7000 && v >= 1000;
    m[4]  = in_bin(h, 31000, 35100) && s >= 1500 && v >= 1000;
    m[5]  = in_bin(h, 1100, 4500) && s >= 1500 && v >= 7500;
    m[6]  = in_bin(h, 1100, 4500) && s >= 1500 && in_bin(v, 1000, 7500);
    m[7]  = in_bin(h, 4500, 6400) && s >= 1500 && v >= 1000;
    m[8]  = in_bin(h, 6400, 15000) && s >= 1500 && v >= 1000;
    m[9]  = in_bin(h, 15000, 18000) && s >= 1500 && v >= 1000;
    m[10] = in_bin(h, 18000, 25500) && s >= 1500 && v >= 1000;
    m[11] = in_bin(h, 25500, 31000) && s >= 5000 && v >= 1000;
    m[12] = in_bin(h, 25500, 31000) && in_bin(s, 1500, 5000) && v >= 1000;
    p.hue = h[15:0]; p.sat = s[13:0]; p.val = v[13:0]; p.mask = m;
    return p;
  endfunction

  always @(posedge clk_i) begin
    hsv_pixel_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) expected_pixels.push_back(convert_pixel(red_i, green_i, blue_i));
      if (valid_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer hue=%0d", hue_i);
        end else begin
          want = expected_pixels.pop_front();
          if (want.hue !== hue_i || want.sat !== saturation_i || want.val !== brightness_i ||
              want.mask !== color_mask_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp h=%0d s=%0d v=%0d m=%h  got h=%0d s=%0d v=%0d m=%h",
                       want.hue, want.sat, want.val, want.mask,
                       hue_i, saturation_i, brightness_i, color_mask_i);
          end
        end
      end
    end
  end

  assign pending_o = expected_pixels.size();
  assign errors_o  = mismatches;
endmodule

### tb/sv/tb_rgb_to_hsv_color_classifier_unit.sv
module tb_rgb_to_hsv_color_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPixels = 1450;
  localparam int CycleLimit   = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic        valid;
  logic [15:0] hue;
  logic [13:0] saturation, brightness;
  logic [12:0] color_mask;
  int          pending, errors;
  int          cycle_count = 0;
  int          idle_pct = 6;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_hsv_color_classifier_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .red_i(red), .green_i(green), .blue_i(blue),
    .valid_o(valid), .hue_o(hue), .saturation_o(saturation),
    .brightness_o(brightness), .color_mask_o(color_mask)
  );

  rgb_to_hsv_color_classifier_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .red_i(red), .green_i(green), .blue_i(blue),
    .valid_i(valid), .hue_i(hue), .saturation_i(saturation),
    .brightness_i(brightness), .color_mask_i(color_mask),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold the pixel until the transfer, with random gaps before it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    red <= r; green <= g; blue <= b;
    // busy depends on registers only, so its value here holds to the next edge
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [7:0] base;
    base = 8'($urandom_range(255, 0));
    case ($urandom_range(4, 0))
      0: send_pixel(base, base, base);
      1: send_pixel(base, base ^ 8'($urandom_range(3, 0)), base ^ 8'($urandom_range(3, 0)));
      2: send_pixel(base, 8'($urandom_range(255, 0)), base);
      default: send_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                          8'($urandom_range(255, 0)));
    endcase
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Extremes, gray, black, each max branch and bin borders.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd25, 8'd25, 8'd25);
    send_pixel(8'd26, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd128, 8'd64, 8'd0);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd150, 8'd200);
    send_pixel(8'd255, 8'd217, 8'd217);
    send_pixel(8'd170, 8'd200, 8'd200);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd255, 8'd46, 8'd0);
    for (int i = 0; i < RandomPixels; i++) begin
      if (i == RandomPixels / 3) idle_pct = 73;
      if (i == 2 * RandomPixels / 3) idle_pct = 0;
      send_random_pixel();
    end
    start <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (25) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
